/* hdl/sdbr_pkg.sv */
`timescale 1ns / 1ps
package sdbr_pkg;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned STRIDE_W = 49;
  localparam int unsigned SIG_W = 4;
  localparam int unsigned SIG_N = 16;
  localparam int unsigned CTR_W = 2;
  localparam logic [1:0] RRPV_MAX = 2'd3;
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [10:0] set_index;
    logic [3:0] way_index;
    logic [47:0] phys_address;
    logic [7:0] pc_low;
    logic       was_hit;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] new_rrpv;
    logic       streaming_seen;
    logic       dead_predicted;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic decay;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic decay_due;
    logic decay_done;
  } sts_t;

  function automatic logic [3:0] sig_of(input logic [7:0] pc);
    return pc[3:0] ^ pc[7:4];
  endfunction

  function automatic logic [1:0] sat_up(input logic [1:0] v);
    return (v == 2'd3) ? v : v + 2'd1;
  endfunction

  function automatic logic [1:0] sat_dn(input logic [1:0] v);
    return (v == 2'd0) ? v : v - 2'd1;
  endfunction
endpackage

/* hdl/sdbr_stream_if.sv */
`timescale 1ns / 1ps
interface sdbr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/sdbr_ram.sv */
`timescale 1ns / 1ps
module sdbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/sdbr_datapath.sv */
`timescale 1ns / 1ps
module sdbr_datapath #(
  parameter int unsigned SETS = 2048,
  parameter int unsigned WAYS = 16,
  parameter int unsigned DECAY_PERIOD = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  sdbr_pkg::cmd_t      cmd,
  output sdbr_pkg::sts_t      sts,
  input  sdbr_pkg::req_t      req,
  output sdbr_pkg::rsp_t      rsp
);
  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = $clog2(WAYS);
  localparam int unsigned PW = $clog2(DECAY_PERIOD + 1);
  localparam int unsigned LINE_W = WAYS * 2;
  localparam int unsigned OUT_W = sdbr_pkg::SIG_N * 2;
  localparam int unsigned SIG_ROW = WAYS * sdbr_pkg::SIG_W;
  localparam int unsigned SET_W = sdbr_pkg::ADDR_W + sdbr_pkg::STRIDE_W + 2;

  sdbr_pkg::req_t        r;
  logic [SW-1:0]         set_q;
  logic [SW-1:0]         set_r;
  logic [WW-1:0]         way_q;
  logic [SW-1:0]         sweep;
  logic                  last_sweep;
  logic [PW-1:0]         upd_cnt;
  logic                  decay_pend;
  logic                  decay_now;
  logic                  dec_v;
  logic [SW-1:0]         dec_addr;

  logic [SW-1:0]         raddr;
  logic [SW-1:0]         waddr;
  logic                  we_rr, we_re, we_sg, we_oc, we_st;
  logic [LINE_W-1:0]     rr_q, rr_w, re_q, re_w;
  logic [SIG_ROW-1:0]    sg_q, sg_w;
  logic [OUT_W-1:0]      oc_q, oc_w;
  logic [SET_W-1:0]      st_q, st_w;

  logic [1:0]            rr_max;
  logic [1:0]            age;
  logic [WW-1:0]         vic;
  logic [sdbr_pkg::ADDR_W-1:0]   paddr;
  logic [sdbr_pkg::STRIDE_W-1:0] pstride, stride;
  logic [1:0]            scnt, scnt_n;
  logic                  streaming, dead;
  logic [3:0]            old_sig, new_sig;
  logic [1:0]            reuse, reuse_n, oc_old, oc_new, rrpv;
  logic [OUT_W-1:0]      oc_tmp;

  sdbr_ram #(.WIDTH(LINE_W), .DEPTH(SETS)) u_rr (
    .clk, .we(we_rr), .waddr, .wdata(rr_w), .raddr, .rdata(rr_q));
  sdbr_ram #(.WIDTH(LINE_W), .DEPTH(SETS)) u_re (
    .clk, .we(we_re), .waddr, .wdata(re_w), .raddr, .rdata(re_q));
  sdbr_ram #(.WIDTH(SIG_ROW), .DEPTH(SETS)) u_sg (
    .clk, .we(we_sg), .waddr, .wdata(sg_w), .raddr, .rdata(sg_q));
  sdbr_ram #(.WIDTH(OUT_W), .DEPTH(SETS)) u_oc (
    .clk, .we(we_oc), .waddr, .wdata(oc_w), .raddr, .rdata(oc_q));
  sdbr_ram #(.WIDTH(SET_W), .DEPTH(SETS)) u_st (
    .clk, .we(we_st), .waddr, .wdata(st_w), .raddr, .rdata(st_q));

  assign set_q = SW'(req.set_index % SETS);
  assign set_r = SW'(r.set_index % SETS);
  assign way_q = WW'(r.way_index % WAYS);
  assign raddr = (cmd.clear || cmd.decay) ? sweep : (cmd.load ? set_q : set_r);
  assign last_sweep = 32'(sweep) == SETS - 1;
  assign decay_now = 32'(upd_cnt) == DECAY_PERIOD - 1;

  always_comb begin
    rr_max = 2'd0;
    vic = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (rr_q[2*i +: 2] > rr_max) rr_max = rr_q[2*i +: 2];
    end
    age = sdbr_pkg::RRPV_MAX - rr_max;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rr_q[2*i +: 2] == rr_max) vic = WW'(i);
    end
  end

  always_comb begin
    {paddr, pstride, scnt} = st_q;
    stride = sdbr_pkg::STRIDE_W'({1'b0, r.phys_address} - {1'b0, paddr});
    scnt_n = (pstride != '0 && stride == pstride) ? sdbr_pkg::sat_up(scnt)
                                                  : sdbr_pkg::sat_dn(scnt);
    streaming = scnt_n >= 2'd2;
    reuse = re_q[2*way_q +: 2];
    dead = reuse == 2'd0;
    old_sig = sg_q[sdbr_pkg::SIG_W*way_q +: sdbr_pkg::SIG_W];
    new_sig = sdbr_pkg::sig_of(r.pc_low);
    oc_old = oc_q[2*old_sig +: 2];
    oc_tmp = oc_q;
    oc_tmp[2*old_sig +: 2] = r.was_hit ? sdbr_pkg::sat_up(oc_old)
                                       : sdbr_pkg::sat_dn(oc_old);
    oc_new = oc_tmp[2*new_sig +: 2];
    reuse_n = r.was_hit ? sdbr_pkg::sat_up(reuse) : sdbr_pkg::sat_dn(reuse);
    if (decay_now) reuse_n = sdbr_pkg::sat_dn(reuse_n);
    if (r.was_hit) rrpv = 2'd0;
    else if (streaming || dead) begin
      rrpv = 2'd3; reuse_n = 2'd0;
    end else if (oc_new >= 2'd2) begin
      rrpv = 2'd1; reuse_n = 2'd2;
    end else begin
      rrpv = 2'd2; reuse_n = 2'd1;
    end
  end

  always_comb begin
    we_rr = 1'b0; we_re = 1'b0; we_sg = 1'b0; we_oc = 1'b0; we_st = 1'b0;
    waddr = sweep;
    rr_w = rr_q; re_w = re_q; sg_w = sg_q; oc_w = oc_tmp;
    st_w = {r.phys_address, stride, scnt_n};
    if (cmd.clear) begin
      {we_rr, we_re, we_sg, we_oc, we_st} = 5'b11111;
      for (int i = 0; i < WAYS; i++) begin
        rr_w[2*i +: 2] = sdbr_pkg::RRPV_MAX;
      end
      re_w = '0; sg_w = '0; st_w = '0;
      for (int i = 0; i < sdbr_pkg::SIG_N; i++) oc_w[2*i +: 2] = 2'd1;
    end else if (dec_v) begin
      waddr = dec_addr;
      we_re = dec_addr != set_r;
      for (int i = 0; i < WAYS; i++) re_w[2*i +: 2] = sdbr_pkg::sat_dn(re_q[2*i +: 2]);
    end else if (cmd.exec) begin
      waddr = set_r;
      we_rr = 1'b1;
      if (r.command == sdbr_pkg::CMD_VICTIM) begin
        for (int i = 0; i < WAYS; i++) rr_w[2*i +: 2] = rr_q[2*i +: 2] + age;
      end else begin
        {we_re, we_sg, we_oc, we_st} = 4'b1111;
        rr_w[2*way_q +: 2] = rrpv;
        if (decay_now) begin
          for (int i = 0; i < WAYS; i++) re_w[2*i +: 2] = sdbr_pkg::sat_dn(re_q[2*i +: 2]);
        end
        re_w[2*way_q +: 2] = reuse_n;
        if (!r.was_hit) sg_w[sdbr_pkg::SIG_W*way_q +: sdbr_pkg::SIG_W] = new_sig;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.exec) begin
      if (r.command == sdbr_pkg::CMD_VICTIM) begin
        rsp <= '{victim_way: 4'(vic), new_rrpv: 2'd0,
                 streaming_seen: 1'b0, dead_predicted: 1'b0};
      end else begin
        rsp <= '{victim_way: 4'd0, new_rrpv: rrpv,
                 streaming_seen: streaming, dead_predicted: dead};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      upd_cnt <= '0;
      decay_pend <= 1'b0;
      dec_v <= 1'b0;
      dec_addr <= '0;
    end else begin
      dec_v <= cmd.decay;
      dec_addr <= sweep;
      if (cmd.clear || cmd.decay) begin
        sweep <= last_sweep ? '0 : sweep + SW'(1);
      end
      if (cmd.decay && last_sweep) decay_pend <= 1'b0;
      if (cmd.exec && r.command == sdbr_pkg::CMD_UPDATE) begin
        if (decay_now) begin
          upd_cnt <= '0;
          decay_pend <= 1'b1;
        end else begin
          upd_cnt <= upd_cnt + PW'(1);
        end
      end
    end
  end

  assign sts.clear_done = last_sweep;
  assign sts.decay_due = decay_pend;
  assign sts.decay_done = last_sweep;
endmodule

/* hdl/sdbr_ctrl.sv */
`timescale 1ns / 1ps
module sdbr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output sdbr_pkg::cmd_t cmd,
  input  sdbr_pkg::sts_t sts
);
  typedef enum logic [2:0] {CLEAR, IDLE, EXEC, DECAY, HOLD} state_t;
  state_t state;
  logic   busy_out;

  assign busy_out = out_valid && !out_ready;
  assign in_ready = (state == IDLE) && !sts.decay_due;
  assign cmd.clear = state == CLEAR;
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == EXEC) && !busy_out;
  assign cmd.decay = state == DECAY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.exec || busy_out;
      unique case (state)
        CLEAR: if (sts.clear_done) state <= IDLE;
        IDLE: begin
          if (sts.decay_due) state <= DECAY;
          else if (cmd.load) state <= EXEC;
        end
        EXEC: if (!busy_out) state <= IDLE;
        DECAY: if (sts.decay_done) state <= HOLD;
        HOLD: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

/* hdl/ship_streaming_dead_block_replacement.sv */
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | command, set_index, way_index, phys_address, pc_low, was_hit
// out     | out | victim_way, new_rrpv, streaming_seen, dead_predicted
// Each item: set read from RAM, then modify and write back before the next.
// After reset a clearing pass over all sets runs before the first item.
// Every DECAY_PERIOD updates, a decay pass over all sets blocks input.
// A result waits in the output register; a stall holds the next item in EXEC.
module ship_streaming_dead_block_replacement #(
  parameter int unsigned SETS = 2048,
  parameter int unsigned WAYS = 16,
  parameter int unsigned DECAY_PERIOD = 4096
) (
  input logic clk,
  input logic rst,
  sdbr_stream_if.sink   in,
  sdbr_stream_if.source out
);
  sdbr_pkg::cmd_t cmd;
  sdbr_pkg::sts_t sts;
  sdbr_pkg::rsp_t rsp;

  sdbr_ctrl u_ctrl (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .cmd, .sts);

  sdbr_datapath #(.SETS(SETS), .WAYS(WAYS), .DECAY_PERIOD(DECAY_PERIOD)) u_dp (
    .clk, .rst, .cmd, .sts, .req(in.data), .rsp);

  assign out.data = rsp;

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !sts.decay_due) else $error("accept during decay");
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.load) else $error("back to back load");
  a_exec_out: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out.valid) else $error("result lost");
endmodule
